/* hw/rtl/indexed_max_table_defines.svh */
// Assertion macros used by the RTL of the indexed maximum table.
`ifndef INDEXED_MAX_TABLE_DEFINES_SVH
`define INDEXED_MAX_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

`define IMT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("indexed_max_table: property failed");

`define IMT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("indexed_max_table: forbidden condition seen");

`else

`define IMT_ASSERT(lbl, clk, rst, prop)

`define IMT_NEVER(lbl, clk, rst, expr)

`endif

`endif

/* hw/rtl/ixmt_pkg.sv */
package ixmt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;

   localparam int REQ_FIELD_BITS = IDX_BITS + VALUE_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = VALUE_BITS + VALUE_BITS + IDX_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_INDEX = 2'd1;
   localparam status_type STATUS_EMPTY     = 2'd2;

endpackage

/* hw/rtl/indexed_max_table.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata: index, value; tuser: write
// rsp      out        rsp_tvalid/tready    tdata: read_value, max_value, max_index;
//                                          tuser: status
// csr      in         csr_valid/ready      csr_data: size_in_use
//
// An item is scanned over the N entries in use (at most 64); when the table is empty
// no entry is read. The single comparator reads one table entry per cycle from the
// RAM.
// Reset is synchronous; the table reads as zero through per-entry valid bits, so
// no clearing pass is needed after reset.
// A new item is taken once the scan is over, even while the previous result
// still waits in the output register; the scan stalls only on a full output.
`include "indexed_max_table_defines.svh"

module indexed_max_table
   import ixmt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // index [5:0], value [37:6], zero padding above
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // write
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // read_value [31:0], max_value [63:32], max_index [69:64], zero padding above
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // status
   output logic [STATUS_BITS-1:0]    rsp_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CNT_BITS-1:0]       csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;
   localparam int   RSP_PAD = RSP_TDATA_BITS - RSP_FIELD_BITS;

   logic                      state_ff, state_in;
   logic [CNT_BITS-1:0]       size_ff, size_in;
   logic [TABLE_DEPTH-1:0]    valid_ff, valid_in;
   logic [IDX_BITS-1:0]       idx_ff, idx_in;
   logic [CNT_BITS-1:0]       used_ff, used_in;
   logic [CNT_BITS-1:0]       addr_ff, addr_in;
   status_type                status_ff, status_in;
   logic [VALUE_BITS-1:0]     max_ff, max_in;
   logic [IDX_BITS-1:0]       max_idx_ff, max_idx_in;
   logic [VALUE_BITS-1:0]     read_ff, read_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0]       rd_idx_ff, rd_idx_in;
   logic                      vb_ff, vb_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   status_type                rsp_tuser_ff, rsp_tuser_in;

   logic [IDX_BITS-1:0]   req_index;
   logic [VALUE_BITS-1:0] req_value;
   logic [CNT_BITS-1:0]   used_now;
   logic                  in_range;
   logic                  req_acc;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [VALUE_BITS-1:0] ram_rd_data;
   logic [VALUE_BITS-1:0] rd_entry;
   logic                  rsp_free;
   logic                  rsp_ld;

   assign req_index = req_tdata[IDX_BITS-1:0];
   assign req_value = req_tdata[REQ_FIELD_BITS-1:IDX_BITS];
   assign used_now  = (size_ff > CNT_BITS'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH) : size_ff;
   assign in_range  = {1'b0, req_index} < used_now;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc   = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_tvalid_ff || rsp_tready;
   assign rd_entry  = vb_ff ? ram_rd_data : '0;

   ixmt_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_index),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff[IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      size_in    = size_ff;
      valid_in   = valid_ff;
      idx_in     = idx_ff;
      used_in    = used_ff;
      addr_in    = addr_ff;
      status_in  = status_ff;
      max_in     = max_ff;
      max_idx_in = max_idx_ff;
      read_in    = read_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      rsp_ld     = 1'b0;

      if (csr_valid && csr_ready) begin
         size_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in   = ST_SCAN;
               idx_in     = req_index;
               used_in    = used_now;
               addr_in    = '0;
               max_in     = '0;
               max_idx_in = '0;
               read_in    = '0;
               if (used_now == '0) begin
                  status_in = STATUS_EMPTY;
               end else if (in_range) begin
                  status_in = STATUS_OK;
               end else begin
                  status_in = STATUS_BAD_INDEX;
               end
               if (in_range && req_tuser) begin
                  ram_wr_en           = 1'b1;
                  valid_in[req_index] = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (addr_ff < used_ff) begin
               ram_rd_en = 1'b1;
               addr_in   = addr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               // Strict compare keeps the lowest index on a tie.
               if (rd_idx_ff == '0 || $signed(rd_entry) > $signed(max_ff)) begin
                  max_in     = rd_entry;
                  max_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == idx_ff && status_ff == STATUS_OK) begin
                  read_in = rd_entry;
               end
            end
            if (addr_ff == used_ff && !rd_vld_ff && rsp_free) begin
               rsp_ld   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_vld_in = ram_rd_en;
   assign rd_idx_in = addr_ff[IDX_BITS-1:0];
   assign vb_in     = valid_ff[addr_ff[IDX_BITS-1:0]];

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (rsp_ld) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{RSP_PAD{1'b0}}, max_idx_ff, max_ff, read_ff};
         rsp_tuser_in  = status_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         size_ff       <= CNT_BITS'(TABLE_DEPTH);
         valid_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         valid_ff      <= valid_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      used_ff      <= used_in;
      addr_ff      <= addr_in;
      status_ff    <= status_in;
      max_ff       <= max_in;
      max_idx_ff   <= max_idx_in;
      read_ff      <= read_in;
      rd_idx_ff    <= rd_idx_in;
      vb_ff        <= vb_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `IMT_ASSERT(a_accept_starts_scan, clock, reset, req_acc |=> (state_ff == ST_SCAN))
   `IMT_NEVER(a_addr_within_used, clock, reset, (state_ff == ST_SCAN) && (addr_ff > used_ff))
   `IMT_NEVER(a_read_within_used, clock, reset, rd_vld_ff && ({1'b0, rd_idx_ff} >= used_ff))
   `IMT_ASSERT(a_load_needs_room, clock, reset, rsp_ld |-> rsp_free)

endmodule

/* hw/rtl/ixmt_ram.sv */
module ixmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
   import ixmt_pkg::*;
();

   typedef struct packed {
      logic [VALUE_BITS-1:0] read_value;
      logic [VALUE_BITS-1:0] max_value;
      logic [IDX_BITS-1:0]   max_index;
      status_type            status;
   } lookup_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CNT_BITS-1:0]       csr_data = '0;

   logic signed [VALUE_BITS-1:0] table_model [TABLE_DEPTH];
   logic [CNT_BITS-1:0]          size_setting;
   lookup_result_type            expected_results [$];
   int                           mismatch_count = 0;
   int                           send_idle_pct = 0;
   int                           rsp_stall_pct = 0;
   logic                         rsp_hold = 1'b0;
   event                         hold_start;

   indexed_max_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int entries_in_use();
      return (size_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_setting);
   endfunction

   function automatic lookup_result_type predict_lookup(input logic [IDX_BITS-1:0] idx,
         input logic [VALUE_BITS-1:0] val, input logic wr);
      lookup_result_type res;
      int                used;
      res = '0;
      used = entries_in_use();
      if (used == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         if (idx < used) begin
            if (wr) begin
               table_model[idx] = val;
            end
            res.read_value = table_model[idx];
            res.status = STATUS_OK;
         end else begin
            res.status = STATUS_BAD_INDEX;
         end
         res.max_value = table_model[0];
         res.max_index = '0;
         for (int i = 1; i < used; i++) begin
            if (table_model[i] > $signed(res.max_value)) begin
               res.max_value = table_model[i];
               res.max_index = IDX_BITS'(i);
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 100) begin
         $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
      end
   endtask

   task automatic send_item(input logic [IDX_BITS-1:0] idx, input logic [VALUE_BITS-1:0] val,
         input logic wr);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_BITS-REQ_FIELD_BITS){1'b0}}, val, idx};
      req_tuser  <= wr;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      expected_results.push_back(predict_lookup(idx, val, wr));
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic write_size(input int unsigned count);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_data  <= CNT_BITS'(count);
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      size_setting = CNT_BITS'(count);
   endtask

   task automatic send_random_item();
      logic [IDX_BITS-1:0]   idx;
      logic [VALUE_BITS-1:0] val;
      int                    used;
      used = entries_in_use();
      if (used > 0 && $urandom_range(99) < 85) begin
         idx = IDX_BITS'($urandom_range(used - 1));
      end else begin
         idx = IDX_BITS'($urandom_range(TABLE_DEPTH - 1));
      end
      case ($urandom_range(9))
         0, 1, 2: val = $urandom_range(6) - 3;
         3: begin
            case ($urandom_range(3))
               0: val = 32'h7fff_ffff;
               1: val = 32'h8000_0000;
               2: val = 32'hffff_ffff;
               default: val = '0;
            endcase
         end
         default: val = $urandom;
      endcase
      send_item(idx, val, $urandom_range(99) < 60);
   endtask

   task automatic test_reset_contents();
      send_item(6'd0, 32'h1234_5678, 1'b0);
      send_item(6'd63, 32'hedcb_a987, 1'b0);
   endtask

   task automatic test_extreme_values();
      send_item(6'd63, 32'h7fff_ffff, 1'b1);
      send_item(6'd5, 32'h8000_0000, 1'b1);
      send_item(6'd0, 32'h7fff_ffff, 1'b1);
      send_item(6'd0, 32'hffff_ffff, 1'b1);
      send_item(6'd5, 32'h0, 1'b0);
   endtask

   task automatic test_bad_index();
      write_size(10);
      send_item(6'd10, 32'h0000_007b, 1'b1);
      send_item(6'd63, 32'h7fff_ffff, 1'b1);
      send_item(6'd9, 32'h0, 1'b0);
   endtask

   task automatic test_empty_table();
      write_size(0);
      send_item(6'd0, 32'h0000_0037, 1'b1);
      send_item(6'd63, 32'h0, 1'b0);
   endtask

   task automatic test_oversized_count();
      write_size(127);
      send_item(6'd63, 32'h0, 1'b0);
      send_item(6'd62, 32'hffff_fffe, 1'b1);
   endtask

   task automatic test_single_entry();
      write_size(1);
      send_item(6'd0, 32'h8000_0000, 1'b1);
      send_item(6'd1, 32'h5555_aaaa, 1'b1);
   endtask

   task automatic test_kept_entries();
      write_size(64);
      send_item(6'd63, 32'h0, 1'b0);
   endtask

   task automatic test_output_backpressure();
      write_size(64);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_start;
      repeat (12) send_random_item();
   endtask

   task automatic test_random_traffic();
      int sz;
      int count;
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 25;
               rsp_stall_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               rsp_stall_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int phase = 0; phase < 5; phase++) begin
            count = 90;
            case (phase)
               0: sz = 64;
               1: sz = $urandom_range(2, 63);
               2: begin
                  sz = (mode == 0) ? 0 : 1;
                  count = (mode == 0) ? 20 : 50;
               end
               3: begin
                  sz = $urandom_range(65, 127);
                  count = 60;
               end
               default: begin
                  sz = $urandom_range(1, 8);
                  count = 80;
               end
            endcase
            write_size(sz);
            repeat (count) send_random_item();
         end
      end
   endtask

   always begin
      @(hold_start);
      rsp_hold <= 1'b1;
      repeat (600) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_tdata), 64'(0));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[VALUE_BITS-1:0] !== want.read_value) begin
               report_mismatch("read_value", 64'(rsp_tdata[VALUE_BITS-1:0]),
                  64'(want.read_value));
            end
            if (rsp_tdata[2*VALUE_BITS-1:VALUE_BITS] !== want.max_value) begin
               report_mismatch("max_value", 64'(rsp_tdata[2*VALUE_BITS-1:VALUE_BITS]),
                  64'(want.max_value));
            end
            if (rsp_tdata[RSP_FIELD_BITS-1:2*VALUE_BITS] !== want.max_index) begin
               report_mismatch("max_index", 64'(rsp_tdata[RSP_FIELD_BITS-1:2*VALUE_BITS]),
                  64'(want.max_index));
            end
            if (rsp_tuser !== want.status) begin
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         table_model[i] = '0;
      end
      size_setting = CNT_BITS'(TABLE_DEPTH);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      test_reset_contents();
      test_extreme_values();
      test_bad_index();
      test_empty_table();
      test_oversized_count();
      test_single_entry();
      test_kept_entries();
      test_output_backpressure();
      test_random_traffic();
      wait_for_idle();
      if (expected_results.size() != 0) begin
         report_mismatch("missing results", 64'(expected_results.size()), 64'(0));
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ixmt_pkg.sv
hw/rtl/ixmt_ram.sv
hw/rtl/indexed_max_table.sv
verif/tb_top.sv
